>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; take this file in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while reset is released.
`define ITOA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("itoa assertion failed");

// Property checked at every edge, reset included.
`define ITOA_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("itoa reset assertion failed");

`endif

>>> rtl/itoa_pkg.sv
// Package for the integer to ASCII digit converter: types, codes and constants.
// No dependencies; used by the cell, the chain, the top level and the testbench.
package itoa_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int HEX_DIGITS = 8;

    // Mode codes of the func field.
    typedef enum logic [2:0] {
        FUNC_UDEC32 = 3'd0,
        FUNC_UDEC64 = 3'd1,
        FUNC_HEX32  = 3'd2,
        FUNC_SDEC32 = 3'd3,
        FUNC_SDEC64 = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    // Digit counts and bit counts of the modes.
    localparam logic [4:0] NDIG_DEC32 = 5'd10;
    localparam logic [4:0] NDIG_DEC64 = 5'd20;
    localparam logic [4:0] NDIG_HEX   = 5'd8;
    localparam logic [6:0] BITS_32    = 7'd32;
    localparam logic [6:0] BITS_64    = 7'd64;

    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h41;

    // Control word that drives every cell of the digit chain.
    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [6:0] ascii_digit(input logic [DIGIT_W-1:0] d);
        logic [6:0] ext;
        ext = {3'b000, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + ext;
        end
        return ASCII_A + ext - 7'd10;
    endfunction

endpackage

>>> rtl/itoa_if.sv
// Valid/ready channel interfaces of the integer to ASCII digit converter.
// Depends on nothing; the top level and the testbench connect through them.
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] number;

    modport source (output valid, output func, output number, input ready);
    modport sink   (input valid, input func, input number, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       negative;
    logic       last;

    modport source (output valid, output digit_char, output negative, output last, input ready);
    modport sink   (input valid, input digit_char, input negative, input last, output ready);
endinterface

>>> rtl/integer_to_ascii_digits.sv
// Integer to ASCII digit converter, top level with control and output register.
// Depends on itoa_pkg, itoa_if and itoa_chain.
//
// Usage: a word on i_in carries a mode (func) and a 64-bit number. The block
// answers on o_out with one word per significant digit, most significant
// first, leading zeros dropped; a zero value gives the single digit '0'.
// Every word of a run carries the same negative flag, and last marks the
// least significant digit. A func code above the signed 64-bit mode is
// taken and dropped without any output.
// Timing: i_in is ready only while the block is idle. Decimal modes run
// one double dabble step per input bit in the cell row (32 or 64 bits),
// then step through the digit positions one by one (10 or 20), a dropped
// leading zero included. Hex mode loads the nibbles directly and then
// steps through its 8 digit positions. The first digit reaches the output
// register after the last conversion step and its leading zeros.
// Stall: o_out is driven from a register; while it holds a word that is
// not taken, the digit row stops emitting (leading zeros still drop). The
// last digit may still wait there while the next input word is accepted.
// Reset (synchronous, active low) clears the state machine, the cells and
// the output valid flag.
module integer_to_ascii_digits (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);
    import itoa_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [63:0] r_mag;
    logic [6:0]  r_bits;
    logic [4:0]  r_rem;
    logic [4:0]  r_ndig;
    logic        r_neg;
    logic        r_started;

    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        r_out_neg;
    logic        r_out_last;

    // Input side decode.
    logic        in_fire;
    logic        func_ok;
    logic        is32;
    logic        is_hex;
    logic        load_neg;
    logic [31:0] mag32;
    logic [63:0] mag64;
    logic [4:0]  load_ndig;

    t_cell_ctrl  cell_ctrl;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] load_digits;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;

    logic [DIGIT_W-1:0] top_digit;
    logic        out_free;
    logic        skip;
    logic        emit;
    logic        step;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        func_ok   = 1'b1;
        is32      = 1'b1;
        is_hex    = 1'b0;
        load_neg  = 1'b0;
        load_ndig = NDIG_DEC32;
        mag32     = i_in.number[31:0];
        mag64     = i_in.number;
        unique case (i_in.func)
            FUNC_UDEC32: begin
            end
            FUNC_UDEC64: begin
                is32      = 1'b0;
                load_ndig = NDIG_DEC64;
            end
            FUNC_HEX32: begin
                is_hex    = 1'b1;
                load_ndig = NDIG_HEX;
            end
            FUNC_SDEC32: begin
                load_neg = i_in.number[31];
                if (i_in.number[31]) begin
                    mag32 = 32'd0 - i_in.number[31:0];
                end
            end
            FUNC_SDEC64: begin
                is32      = 1'b0;
                load_ndig = NDIG_DEC64;
                load_neg  = i_in.number[63];
                if (i_in.number[63]) begin
                    mag64 = 64'd0 - i_in.number;
                end
            end
            default: begin
                func_ok = 1'b0;
            end
        endcase
    end

    // Hex mode places the nibbles straight into the cells; decimal starts at zero.
    always_comb begin
        load_digits = '0;
        if (is_hex) begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
                load_digits[i] = i_in.number[4*i +: 4];
            end
        end
    end

    // The most significant digit of the mode sits in a fixed cell.
    always_comb begin
        unique case (r_ndig)
            NDIG_HEX:   top_digit = digits[HEX_DIGITS-1];
            NDIG_DEC32: top_digit = digits[NUM_DIGITS/2-1];
            default:    top_digit = digits[NUM_DIGITS-1];
        endcase
    end

    // Leading zeros are dropped without waiting for the output register.
    assign skip = (r_state == S_EMIT) && !r_started && (top_digit == '0) && (r_rem > 5'd1);
    assign emit = (r_state == S_EMIT) && !skip && out_free;
    assign step = skip || emit;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && func_ok) begin
                    n_state = is_hex ? S_EMIT : S_CONV;
                end
            end
            S_CONV: begin
                if (r_bits == 7'd1) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (step && (r_rem == 5'd1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        i_in.ready      = 1'b0;
        cell_ctrl.load  = 1'b0;
        cell_ctrl.conv  = 1'b0;
        cell_ctrl.shift = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready     = 1'b1;
                cell_ctrl.load = in_fire && func_ok;
            end
            S_CONV: begin
                cell_ctrl.conv = 1'b1;
            end
            S_EMIT: begin
                cell_ctrl.shift = step;
            end
            default: begin
            end
        endcase
    end

    itoa_chain u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (cell_ctrl),
        .i_load_digits (load_digits),
        .i_carry       (r_mag[63]),
        .o_digits      (digits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bits    <= '0;
            r_rem     <= '0;
            r_ndig    <= NDIG_DEC32;
            r_neg     <= 1'b0;
            r_started <= 1'b0;
            r_mag     <= '0;
        end else begin
            r_state <= n_state;
            if (cell_ctrl.load) begin
                r_mag     <= is32 ? {mag32, 32'd0} : mag64;
                r_bits    <= is32 ? BITS_32 : BITS_64;
                r_ndig    <= load_ndig;
                r_rem     <= load_ndig;
                r_neg     <= load_neg;
                r_started <= 1'b0;
            end else if (cell_ctrl.conv) begin
                r_mag  <= {r_mag[62:0], 1'b0};
                r_bits <= r_bits - 7'd1;
            end else if (step) begin
                r_rem <= r_rem - 5'd1;
                if (emit) begin
                    r_started <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= ascii_digit(top_digit);
            r_out_neg  <= r_neg;
            r_out_last <= (r_rem == 5'd1);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_out_char;
    assign o_out.negative   = r_out_neg;
    assign o_out.last       = r_out_last;

endmodule

>>> rtl/itoa_cell.sv
// One BCD digit cell: add-3 correction and shift during conversion, shift up on output.
// Depends on itoa_pkg.
module itoa_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itoa_pkg::t_cell_ctrl i_ctrl,
    input  logic [3:0]           i_load_digit,
    input  logic                 i_carry,
    input  logic [3:0]           i_below,
    output logic [3:0]           o_digit,
    output logic                 o_carry
);
    import itoa_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    always_comb begin
        adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
        n_digit = r_digit;
        if (i_ctrl.load) begin
            n_digit = i_load_digit;
        end else if (i_ctrl.conv) begin
            n_digit = {adj[2:0], i_carry};
        end else if (i_ctrl.shift) begin
            n_digit = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;
    assign o_carry = adj[3];

endmodule

>>> rtl/itoa_chain.sv
// Row of BCD digit cells; carries ripple up during conversion, digits move up on output.
// Depends on itoa_pkg and itoa_cell.
module itoa_chain (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  itoa_pkg::t_cell_ctrl                                  i_ctrl,
    input  logic [itoa_pkg::NUM_DIGITS-1:0][itoa_pkg::DIGIT_W-1:0] i_load_digits,
    input  logic                                                  i_carry,
    output logic [itoa_pkg::NUM_DIGITS-1:0][itoa_pkg::DIGIT_W-1:0] o_digits
);
    import itoa_pkg::*;

    logic [NUM_DIGITS-1:0] carry;

    assign carry[0] = i_carry;

    for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_cell
        logic [DIGIT_W-1:0] below;
        if (d == 0) begin : g_first
            assign below = '0;
        end else begin : g_rest
            assign below = o_digits[d-1];
        end
        if (d < NUM_DIGITS - 1) begin : g_mid
            itoa_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_load_digit (i_load_digits[d]),
                .i_carry      (carry[d]),
                .i_below      (below),
                .o_digit      (o_digits[d]),
                .o_carry      (carry[d+1])
            );
        end else begin : g_top
            // The top digit never overflows for a 64-bit value.
            itoa_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_load_digit (i_load_digits[d]),
                .i_carry      (carry[d]),
                .i_below      (below),
                .o_digit      (o_digits[d]),
                .o_carry      ()
            );
        end
    end

endmodule

>>> rtl/itoa_checker.sv
// Port-level checker for the integer to ASCII digit converter, bound to the top level.
// Depends on assert_macros.svh and the integer_to_ascii_digits ports.
`include "assert_macros.svh"

module itoa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_neg,
    input logic       i_out_last
);

    logic       out_wait;
    logic       out_take_mid;
    logic       char_ok;
    logic [8:0] out_word;

    assign out_wait     = i_out_valid && !i_out_ready;
    assign out_take_mid = i_out_valid && i_out_ready && !i_out_last;
    assign out_word     = {i_out_char, i_out_neg, i_out_last};
    assign char_ok      = (i_out_char >= 7'h30 && i_out_char <= 7'h39) ||
                          (i_out_char >= 7'h41 && i_out_char <= 7'h46);

    // A held word stays unchanged until it is taken.
    `ITOA_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> (i_out_valid && $stable(out_word)))

    // Only decimal digits and upper-case hex letters leave the block.
    `ITOA_ASSERT(a_char_range, i_clk, i_rst_n, i_out_valid |-> char_ok)

    // No new number is taken while a digit other than the last of a run waits at the output.
    `ITOA_ASSERT(a_busy_in_run, i_clk, i_rst_n, (i_out_valid && !i_out_last) |-> !i_in_ready)

    // Once a run has started, digits follow back to back with one sign.
    `ITOA_ASSERT(a_run_dense, i_clk, i_rst_n, out_take_mid |=> (i_out_valid && $stable(i_out_neg)))

    // Reset empties the output register.
    `ITOA_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.digit_char),
    .i_out_neg   (o_out.negative),
    .i_out_last  (o_out.last)
);

>>> sim/integer_to_ascii_digits_tb.sv
// Self-checking testbench for the integer to ASCII digit converter.
// Depends on itoa_pkg, itoa_if and the integer_to_ascii_digits RTL.
// A directed table runs first, then random words, all checked against typed table strings or a predictor.
module integer_to_ascii_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    // Mode codes the block takes and drops without output.
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_WORDS = 250;
    localparam int          CALM_FROM    = 210;
    localparam int          HOLD_AT      = 120;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       negative;
        logic       last;
    } digit_word_t;

    typedef digit_word_t digit_run_t[$];

    // One row of the directed table. When typed is set, the digit string and the
    // sign flag are the expected output; otherwise the predictor supplies it.
    typedef struct {
        logic [2:0]  func;
        logic [63:0] number;
        bit          typed;
        bit          neg;
        string       digits;
    } dir_row_t;

    logic clk;
    logic rst_n;

    itoa_in_if  in_ch ();
    itoa_out_if out_ch ();

    integer_to_ascii_digits u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: BCD digit row (least significant first), the last
    // converted magnitude and the number of bits shifted in.
    logic [3:0]  bcd_digits [NUM_DIGITS];
    logic [63:0] last_magnitude;
    logic [6:0]  conv_bits;

    digit_word_t expected_digits[$];
    int unsigned cycle_count;
    int          mismatch_count;
    bit          idling_on;
    bit          hold_request;
    dir_row_t    directed_rows [24];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift-and-add-3 over the low 'width' bits of mag, most significant first, into the BCD row.
    function automatic void run_dabble(input logic [63:0] mag, input int width);
        logic       carry;
        logic [4:0] v;
        for (int d = 0; d < NUM_DIGITS; d++) bcd_digits[d] = '0;
        for (int b = 0; b < width; b++) begin
            carry = mag[width - 1 - b];
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd_digits[d] >= 4'd5) bcd_digits[d] = bcd_digits[d] + 4'd3;
            end
            for (int d = 0; d < NUM_DIGITS; d++) begin
                v = {bcd_digits[d], carry};
                carry = v[4];
                bcd_digits[d] = v[3:0];
            end
        end
        conv_bits = 7'(width);
    endfunction

    // Works out the digit words one input word produces. Spare mode codes give
    // an empty run and leave the state alone.
    function automatic void predict_digits(input logic [2:0] f, input logic [63:0] num,
                                           output digit_run_t run);
        logic [63:0] mag;
        logic        neg;
        int          ndig;
        int          top;
        digit_word_t w;
        run = {};
        neg = 1'b0;
        mag = '0;
        case (f)
            FUNC_UDEC32: begin
                mag[31:0] = num[31:0];
                run_dabble(mag, 32);
                ndig = NDIG_DEC32;
            end
            FUNC_UDEC64: begin
                mag = num;
                run_dabble(mag, 64);
                ndig = NDIG_DEC64;
            end
            FUNC_HEX32: begin
                mag[31:0] = num[31:0];
                for (int d = 0; d < NUM_DIGITS; d++) bcd_digits[d] = '0;
                for (int d = 0; d < HEX_DIGITS; d++) bcd_digits[d] = mag[4 * d +: 4];
                conv_bits = BITS_32;
                ndig = NDIG_HEX;
            end
            FUNC_SDEC32: begin
                mag[31:0] = num[31:0];
                if (num[31]) begin
                    neg = 1'b1;
                    mag[31:0] = 32'd0 - num[31:0];
                end
                run_dabble(mag, 32);
                ndig = NDIG_DEC32;
            end
            FUNC_SDEC64: begin
                mag = num;
                if (num[63]) begin
                    neg = 1'b1;
                    mag = 64'd0 - num;
                end
                run_dabble(mag, 64);
                ndig = NDIG_DEC64;
            end
            default: return;
        endcase
        last_magnitude = mag;

        // Leading zeros are dropped, but a zero value still gives one digit.
        top = 0;
        for (int i = 0; i < ndig; i++) begin
            if (bcd_digits[i] != 4'd0) top = i;
        end
        for (int i = top; i >= 0; i--) begin
            if (bcd_digits[i] < 4'd10) begin
                w.digit_char = ASCII_ZERO + {3'b000, bcd_digits[i]};
            end else begin
                w.digit_char = ASCII_A + {3'b000, bcd_digits[i]} - 7'd10;
            end
            w.negative = neg;
            w.last     = (i == 0);
            run.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Offers one word, with a random gap in front when idling is on, and
    // queues its expected digits at the edge that accepts it. Valid stays
    // high on return so that a following word goes out back to back.
    task automatic send_word(input logic [2:0] f, input logic [63:0] num,
                             input digit_run_t run);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.number <= num;
        do @(posedge clk); while (!in_ch.ready);
        foreach (run[i]) expected_digits.push_back(run[i]);
        @(negedge clk);
    endtask

    // Run limit: a hung block ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_to_ascii_digits_tb NOT OK");
            $finish;
        end
    end

    // Output checker: every accepted word is matched against the oldest expectation.
    always @(posedge clk) begin
        digit_word_t got;
        digit_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.digit_char = out_ch.digit_char;
            got.negative   = out_ch.negative;
            got.last       = out_ch.last;
            if (expected_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%h neg=%b last=%b",
                                          got.digit_char, got.negative, got.last));
            end else begin
                want = expected_digits.pop_front();
                if (got.digit_char !== want.digit_char)
                    report_mismatch($sformatf("digit_char %h, expected %h",
                                              got.digit_char, want.digit_char));
                if (got.negative !== want.negative)
                    report_mismatch($sformatf("negative %b, expected %b",
                                              got.negative, want.negative));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
        end
    end

    // Receiver: random stall bursts while idling is on, and one long hold-off
    // on request so that the block backs up into its input.
    initial begin : digit_sink
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        digit_run_t  run;
        digit_word_t w;
        byte         ch;
        logic [2:0]  f;
        logic [63:0] num;
        int          real_words;
        bit          hold_done;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_UDEC32;
        in_ch.number   = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        idling_on      = 1'b1;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        real_words     = 0;
        for (int d = 0; d < NUM_DIGITS; d++) bcd_digits[d] = '0;
        last_magnitude = '0;
        conv_bits      = '0;

        directed_rows = '{
            '{FUNC_UDEC32,  64'd0,                     1'b1, 1'b0, "0"},
            '{FUNC_UDEC32,  64'h0000_0000_FFFF_FFFF,   1'b1, 1'b0, "4294967295"},
            '{FUNC_UDEC32,  64'hFFFF_FFFF_0000_0001,   1'b1, 1'b0, "1"},
            '{FUNC_UDEC64,  64'd0,                     1'b1, 1'b0, "0"},
            '{FUNC_UDEC64,  64'hFFFF_FFFF_FFFF_FFFF,   1'b1, 1'b0, "18446744073709551615"},
            '{FUNC_UDEC64,  64'd12345678901234567890,  1'b0, 1'b0, ""},
            '{FUNC_HEX32,   64'd0,                     1'b1, 1'b0, "0"},
            '{FUNC_HEX32,   64'h0000_0000_FFFF_FFFF,   1'b1, 1'b0, "FFFFFFFF"},
            '{FUNC_HEX32,   64'h0000_0000_0123_ABCD,   1'b1, 1'b0, "123ABCD"},
            '{FUNC_HEX32,   64'hDEAD_BEEF_0000_000A,   1'b1, 1'b0, "A"},
            '{FUNC_SDEC32,  64'h0000_0000_8000_0000,   1'b1, 1'b1, "2147483648"},
            '{FUNC_SDEC32,  64'h0000_0000_7FFF_FFFF,   1'b1, 1'b0, "2147483647"},
            '{FUNC_SDEC32,  64'h0000_0000_FFFF_FFFF,   1'b1, 1'b1, "1"},
            '{FUNC_SDEC32,  64'hFFFF_FFFF_0000_0005,   1'b1, 1'b0, "5"},
            '{FUNC_SDEC32,  64'h0000_0000_FFFF_CFC7,   1'b0, 1'b0, ""},
            '{FUNC_SDEC64,  64'h8000_0000_0000_0000,   1'b1, 1'b1, "9223372036854775808"},
            '{FUNC_SDEC64,  64'h7FFF_FFFF_FFFF_FFFF,   1'b1, 1'b0, "9223372036854775807"},
            '{FUNC_SDEC64,  64'hFFFF_FFFF_FFFF_FFFF,   1'b1, 1'b1, "1"},
            '{FUNC_SDEC64,  64'd0,                     1'b1, 1'b0, "0"},
            '{FUNC_SPARE_5, 64'hFFFF_FFFF_FFFF_FFFF,   1'b1, 1'b0, ""},
            '{FUNC_SPARE_6, 64'h0000_0000_0000_1234,   1'b1, 1'b0, ""},
            '{FUNC_SPARE_7, 64'd0,                     1'b1, 1'b0, ""},
            '{FUNC_UDEC32,  64'd1000000000,            1'b0, 1'b0, ""},
            '{FUNC_UDEC64,  64'd10,                    1'b0, 1'b0, ""}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: extremes, every mode, spare codes, the most negative values
        // and the high half of the number ignored in 32-bit modes.
        foreach (directed_rows[r]) begin
            predict_digits(directed_rows[r].func, directed_rows[r].number, run);
            if (directed_rows[r].typed) begin
                run = {};
                for (int k = 0; k < directed_rows[r].digits.len(); k++) begin
                    ch = directed_rows[r].digits[k];
                    w.digit_char = ch[6:0];
                    w.negative   = directed_rows[r].neg;
                    w.last       = (k == directed_rows[r].digits.len() - 1);
                    run.push_back(w);
                end
            end
            send_word(directed_rows[r].func, directed_rows[r].number, run);
        end

        // Random part. Idling switches off for one segment in three and for the
        // tail of the run; the long hold-off is requested once in the middle.
        while (real_words < RANDOM_WORDS) begin
            idling_on = (real_words < CALM_FROM) && ((real_words / 40) % 3 != 2);
            if (real_words >= HOLD_AT && !hold_done) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                f = 3'($urandom_range(FUNC_SPARE_7, FUNC_SPARE_5));
            end else begin
                f = 3'($urandom_range(FUNC_SDEC64, FUNC_UDEC32));
            end
            // Spread the magnitudes so that every digit count shows up.
            num = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: num = num >> $urandom_range(0, 63);
                1: num = ~(num >> $urandom_range(0, 63));
                2: num = 64'($urandom_range(0, 20));
                default: ;
            endcase
            predict_digits(f, num, run);
            send_word(f, num, run);
            if (f <= FUNC_SDEC64) real_words++;
        end
        in_ch.valid <= 1'b0;

        while (expected_digits.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0) begin
            $display("integer_to_ascii_digits_tb OK");
        end else begin
            $display("integer_to_ascii_digits_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> integer_to_ascii_digits.f
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/itoa_cell.sv
rtl/itoa_chain.sv
rtl/integer_to_ascii_digits.sv
rtl/itoa_checker.sv
sim/integer_to_ascii_digits_tb.sv
